// ===== sv/smt_pkg.sv =====
// Shared types and constants of the sorted multimap table core.
// Used by smt_ctrl, smt_dp and sorted_multimap_table_core; has no dependencies.
package smt_pkg;

    localparam int CAPACITY = 16;
    localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW       = $clog2(CAPACITY + 1);
    localparam int KW       = 32;
    localparam int VW       = 32;
    localparam int EW       = KW + VW;
    localparam int ENTRY_W  = 5;

    // Commands of the input word.
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;

    // Status codes of the result word.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;

    // Read address selection.
    localparam logic [1:0] RD_IDX = 2'd0;
    localparam logic [1:0] RD_DN  = 2'd1;
    localparam logic [1:0] RD_UP  = 2'd2;

    // Index register operations.
    localparam logic [1:0] IDX_HOLD = 2'd0;
    localparam logic [1:0] IDX_INC  = 2'd1;
    localparam logic [1:0] IDX_DEC  = 2'd2;
    localparam logic [1:0] IDX_POS  = 2'd3;

    // Result word source.
    localparam logic [1:0] OUT_CODE = 2'd0;
    localparam logic [1:0] OUT_MID  = 2'd1;
    localparam logic [1:0] OUT_LAST = 2'd2;

    typedef struct packed {
        logic       cap;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic [1:0] idx_op;
        logic       wr_en;
        logic       wr_new;
        logic       fill_inc;
        logic       fill_dec;
        logic       pend_ld;
        logic       out_ld;
        logic [1:0] out_sel;
        logic [1:0] out_code;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic scan_end;
        logic sh_done;
        logic rm_done;
        logic rel;
        logic key_eq;
        logic kv_eq;
        logic have_pend;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== sv/smt_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module smt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/smt_ctrl.sv =====
// Sequencer of the sorted multimap table: scan, shift and result steps.
// Depends on smt_pkg; drives smt_dp through t_dp_cmd and reads t_dp_sts.
module smt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_cmd,
    input  smt_pkg::t_dp_sts i_sts,
    output smt_pkg::t_dp_cmd o_cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SCAN_RD = 4'd1;
    localparam logic [3:0] S_SCAN_EV = 4'd2;
    localparam logic [3:0] S_SH_RD   = 4'd3;
    localparam logic [3:0] S_SH_WR   = 4'd4;
    localparam logic [3:0] S_PUT     = 4'd5;
    localparam logic [3:0] S_RM_RD   = 4'd6;
    localparam logic [3:0] S_RM_WR   = 4'd7;
    localparam logic [3:0] S_EMIT    = 4'd8;
    localparam logic [3:0] S_FIN     = 4'd9;

    logic [3:0] r_state, n_state;
    logic [1:0] r_op, n_op;
    logic [1:0] r_code, n_code;
    smt_pkg::t_dp_cmd c_cmd;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_code  = r_code;
        c_cmd   = '0;
        c_cmd.out_code = r_code;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    c_cmd.cap = 1'b1;
                    n_op      = i_cmd;
                    if (i_cmd == smt_pkg::CMD_INSERT) begin
                        if (i_sts.full) begin
                            n_code  = smt_pkg::ST_FULL;
                            n_state = S_EMIT;
                        end else begin
                            n_state = S_SCAN_RD;
                        end
                    end else if (i_cmd == smt_pkg::CMD_REMOVE ||
                                 i_cmd == smt_pkg::CMD_SEARCH) begin
                        n_state = S_SCAN_RD;
                    end else begin
                        n_code  = smt_pkg::ST_NONE;
                        n_state = S_EMIT;
                    end
                end
            end
            S_SCAN_RD: begin
                if (i_sts.scan_end) begin
                    if (r_op == smt_pkg::CMD_INSERT) begin
                        c_cmd.idx_op = smt_pkg::IDX_POS;
                        n_state      = S_SH_RD;
                    end else if (r_op == smt_pkg::CMD_REMOVE) begin
                        n_code  = smt_pkg::ST_NONE;
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    c_cmd.rd_en  = 1'b1;
                    c_cmd.rd_sel = smt_pkg::RD_IDX;
                    n_state      = S_SCAN_EV;
                end
            end
            S_SCAN_EV: begin
                if (r_op == smt_pkg::CMD_INSERT) begin
                    if (i_sts.rel) begin
                        c_cmd.idx_op = smt_pkg::IDX_INC;
                        n_state      = S_SCAN_RD;
                    end else begin
                        c_cmd.idx_op = smt_pkg::IDX_POS;
                        n_state      = S_SH_RD;
                    end
                end else if (r_op == smt_pkg::CMD_REMOVE) begin
                    if (i_sts.kv_eq) begin
                        n_state = S_RM_RD;
                    end else begin
                        c_cmd.idx_op = smt_pkg::IDX_INC;
                        n_state      = S_SCAN_RD;
                    end
                end else if (i_sts.key_eq) begin
                    // A new match releases the held one, which is not the last.
                    if (!i_sts.have_pend || i_sts.out_free) begin
                        c_cmd.out_ld  = i_sts.have_pend;
                        c_cmd.out_sel = smt_pkg::OUT_MID;
                        c_cmd.pend_ld = 1'b1;
                        c_cmd.idx_op  = smt_pkg::IDX_INC;
                        n_state       = S_SCAN_RD;
                    end
                end else begin
                    c_cmd.idx_op = smt_pkg::IDX_INC;
                    n_state      = S_SCAN_RD;
                end
            end
            S_SH_RD: begin
                if (i_sts.sh_done) begin
                    n_state = S_PUT;
                end else begin
                    c_cmd.rd_en  = 1'b1;
                    c_cmd.rd_sel = smt_pkg::RD_DN;
                    n_state      = S_SH_WR;
                end
            end
            S_SH_WR: begin
                c_cmd.wr_en  = 1'b1;
                c_cmd.idx_op = smt_pkg::IDX_DEC;
                n_state      = S_SH_RD;
            end
            S_PUT: begin
                c_cmd.wr_en    = 1'b1;
                c_cmd.wr_new   = 1'b1;
                c_cmd.fill_inc = 1'b1;
                n_code         = smt_pkg::ST_OK;
                n_state        = S_EMIT;
            end
            S_RM_RD: begin
                if (i_sts.rm_done) begin
                    c_cmd.fill_dec = 1'b1;
                    n_code         = smt_pkg::ST_OK;
                    n_state        = S_EMIT;
                end else begin
                    c_cmd.rd_en  = 1'b1;
                    c_cmd.rd_sel = smt_pkg::RD_UP;
                    n_state      = S_RM_WR;
                end
            end
            S_RM_WR: begin
                c_cmd.wr_en  = 1'b1;
                c_cmd.idx_op = smt_pkg::IDX_INC;
                n_state      = S_RM_RD;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    c_cmd.out_ld  = 1'b1;
                    c_cmd.out_sel = smt_pkg::OUT_CODE;
                    n_state       = S_IDLE;
                end
            end
            S_FIN: begin
                c_cmd.out_code = smt_pkg::ST_NONE;
                if (i_sts.out_free) begin
                    c_cmd.out_ld  = 1'b1;
                    c_cmd.out_sel = i_sts.have_pend ? smt_pkg::OUT_LAST
                                                    : smt_pkg::OUT_CODE;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= smt_pkg::CMD_INSERT;
            r_code  <= smt_pkg::ST_OK;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_code  <= n_code;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = c_cmd;

    // An insert into a full table goes straight to the refusal result.
    a_full_refused : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && i_cmd == smt_pkg::CMD_INSERT && i_sts.full)
        |=> (r_state == S_EMIT && r_code == smt_pkg::ST_FULL))
        else $error("insert into a full table was not refused");

    // The table is never written while a word can be accepted.
    a_no_write_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !c_cmd.wr_en)
        else $error("table written while idle");

    // The state register only ever holds one of the defined states.
    a_state_legal : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state <= S_FIN)
        else $error("undefined sequencer state");

endmodule

// ===== sv/smt_dp.sv =====
// Datapath of the sorted multimap table: entry memory, indexes, fill count,
// held search match and result register. Depends on smt_pkg and smt_ram.
module smt_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  smt_pkg::t_dp_cmd     i_cmd,
    output smt_pkg::t_dp_sts     o_sts,
    input  logic signed [31:0]   i_key,
    input  logic signed [31:0]   i_value,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_status,
    output logic signed [31:0]   o_found_value,
    output logic                 o_last,
    output logic [4:0]           o_entry_count
);

    logic                          r_desc;
    logic signed [smt_pkg::KW-1:0] r_key;
    logic signed [smt_pkg::VW-1:0] r_val;
    logic signed [smt_pkg::VW-1:0] r_pend;
    logic                          r_have;
    logic [smt_pkg::CW-1:0]        r_idx, r_pos, r_fill;
    logic [smt_pkg::CW-1:0]        c_idx_dn, c_idx_up;
    logic [smt_pkg::AW-1:0]        c_raddr, c_waddr;
    logic [smt_pkg::EW-1:0]        c_wdata, c_rdata;
    logic signed [smt_pkg::KW-1:0] c_rkey;
    logic signed [smt_pkg::VW-1:0] c_rval;
    logic                          c_out_free;

    logic                          r_out_valid, r_last;
    logic [1:0]                    r_status;
    logic signed [31:0]            r_found;
    logic [smt_pkg::ENTRY_W-1:0]   r_count;

    assign c_idx_dn = r_idx - 1'b1;
    assign c_idx_up = r_idx + 1'b1;

    always_comb begin
        case (i_cmd.rd_sel)
            smt_pkg::RD_DN: c_raddr = c_idx_dn[smt_pkg::AW-1:0];
            smt_pkg::RD_UP: c_raddr = c_idx_up[smt_pkg::AW-1:0];
            default:        c_raddr = r_idx[smt_pkg::AW-1:0];
        endcase
    end

    assign c_waddr = i_cmd.wr_new ? r_pos[smt_pkg::AW-1:0] : r_idx[smt_pkg::AW-1:0];
    assign c_wdata = i_cmd.wr_new ? {r_key, r_val} : c_rdata;

    smt_ram #(
        .WIDTH(smt_pkg::EW),
        .DEPTH(smt_pkg::CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.wr_en),
        .i_waddr(c_waddr),
        .i_wdata(c_wdata),
        .i_re   (i_cmd.rd_en),
        .i_raddr(c_raddr),
        .o_rdata(c_rdata)
    );

    assign c_rkey = c_rdata[smt_pkg::EW-1:smt_pkg::VW];
    assign c_rval = c_rdata[smt_pkg::VW-1:0];

    assign c_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_sts           = '0;
        o_sts.full      = (r_fill == smt_pkg::CW'(smt_pkg::CAPACITY));
        o_sts.scan_end  = (r_idx == r_fill);
        o_sts.sh_done   = (r_idx == r_pos);
        o_sts.rm_done   = (c_idx_up == r_fill);
        o_sts.rel       = r_desc ? (c_rkey >= r_key) : (c_rkey <= r_key);
        o_sts.key_eq    = (c_rkey == r_key);
        o_sts.kv_eq     = (c_rkey == r_key) && (c_rval == r_val);
        o_sts.have_pend = r_have;
        o_sts.out_free  = c_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desc      <= 1'b0;
            r_fill      <= '0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_desc <= i_cfg_wdata;
            end
            if (i_cmd.fill_inc) begin
                r_fill <= r_fill + 1'b1;
            end else if (i_cmd.fill_dec) begin
                r_fill <= r_fill - 1'b1;
            end
            if (i_cmd.cap) begin
                r_have <= 1'b0;
            end else if (i_cmd.pend_ld) begin
                r_have <= 1'b1;
            end
            if (i_cmd.out_ld) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_key <= i_key;
            r_val <= i_value;
            r_idx <= '0;
        end else begin
            case (i_cmd.idx_op)
                smt_pkg::IDX_INC: r_idx <= c_idx_up;
                smt_pkg::IDX_DEC: r_idx <= c_idx_dn;
                smt_pkg::IDX_POS: begin
                    r_pos <= r_idx;
                    r_idx <= r_fill;
                end
                default: r_idx <= r_idx;
            endcase
        end
        if (i_cmd.pend_ld) begin
            r_pend <= c_rval;
        end
        if (i_cmd.out_ld) begin
            r_count <= smt_pkg::ENTRY_W'(r_fill);
            case (i_cmd.out_sel)
                smt_pkg::OUT_MID: begin
                    r_status <= smt_pkg::ST_OK;
                    r_found  <= r_pend;
                    r_last   <= 1'b0;
                end
                smt_pkg::OUT_LAST: begin
                    r_status <= smt_pkg::ST_OK;
                    r_found  <= r_pend;
                    r_last   <= 1'b1;
                end
                default: begin
                    r_status <= i_cmd.out_code;
                    r_found  <= '0;
                    r_last   <= 1'b1;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_found_value = r_found;
    assign o_last        = r_last;
    assign o_entry_count = r_count;

    a_fill_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= smt_pkg::CW'(smt_pkg::CAPACITY))
        else $error("fill count above capacity");

    a_out_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_ld |-> c_out_free)
        else $error("result register overwritten before it was taken");

    a_fill_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fill_inc |=> (r_fill == $past(r_fill) + 1'b1))
        else $error("fill count did not advance on insert");

endmodule

// ===== sv/sorted_multimap_table_core.sv =====
// Top level of the sorted multimap table core.
// Depends on smt_pkg, smt_ctrl, smt_dp and smt_ram.
//
// Sorted multimap table: holds up to smt_pkg::CAPACITY key/value pairs in
// signed key order, ascending or descending as chosen by the one-bit
// configuration register (i_cfg_we / i_cfg_wdata, write only while idle;
// changing it does not re-sort stored pairs). Each input word carries a
// command: insert places the pair after every leading entry whose key relates
// to it (so after equal keys) and is refused with status "full" at capacity;
// remove deletes the first pair matching both key and value, or answers
// "no match"; search returns every value stored under the key, in table
// order, one result word each, with o_last on the final one, or a single
// "no match" word. Every result word also carries the entry count after the
// operation. Entries live in one RAM with a write port, a read port and a
// registered read, so each table entry visited takes an address step, then
// a compare or move step: an insert scans to the slot, then shifts the tail
// up, and a search may also wait on the result side. One word is worked on
// at a time; the next is accepted as soon as the previous one's last result
// sits in the output register, even if that result has not yet been taken.
// No clearing pass is needed after reset: only entries below the fill count
// are read.
module sorted_multimap_table_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_cmd,
    input  logic signed [31:0] i_key,
    input  logic signed [31:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_found_value,
    output logic               o_last,
    output logic [4:0]         o_entry_count,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata
);

    // Command and status between the sequencer and the datapath.
    smt_pkg::t_dp_cmd w_cmd;
    smt_pkg::t_dp_sts w_sts;

    smt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_cmd     (i_cmd),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    // The datapath captures the input word when the sequencer accepts it.
    smt_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_key        (i_key),
        .i_value      (i_value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_found_value(o_found_value),
        .o_last       (o_last),
        .o_entry_count(o_entry_count)
    );

endmodule
